[sv/assert_macros.svh]
// Assertion macros shared by the pulse length word decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PLWD_ASSERT(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define PLWD_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define PLWD_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/plwd_pkg.sv]
// Shared types, constants and helpers of the pulse length word decoder.
`default_nettype none
package plwd_pkg;

   localparam int WORD_BITS_DEFAULT         = 45;
   localparam int FULL_PERIOD_UNITS_DEFAULT = 64;

   localparam int UNIT_TICKS_W    = 10;
   localparam int TOLERANCE_W     = 5;
   localparam int PULSE_W         = 16;
   localparam int UNITS_W         = 10;
   localparam int BOUND_W         = UNIT_TICKS_W + UNITS_W;
   localparam int COUNT_W         = 6;
   localparam int FIELD_SPAN      = 64;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int REQ_TDATA_W     = 16;
   localparam int RSP_TDATA_W     = 56;

   localparam logic [UNIT_TICKS_W-1:0] UNIT_TICKS_RESET = 10'd192;
   localparam logic [TOLERANCE_W-1:0]  TOLERANCE_RESET  = 5'd8;

   // register indexes on the configuration port
   localparam logic REG_UNIT_TICKS = 1'b0;
   localparam logic REG_TOLERANCE  = 1'b1;

   // pulse windows, tried in this order on pulses other than a word start
   localparam int WIN_FULL     = 0;
   localparam int WIN_ONE_HALF = 1;
   localparam int WIN_DOUBLE   = 2;
   localparam int WIN_TRIPLE   = 3;
   localparam int NUM_WINDOWS  = 4;

   // field positions in the word buffer
   localparam int ROW_STRIDE    = 9;
   localparam int ROW_CHECK_POS = 8;
   localparam int COL_FIRST     = 36;
   localparam int STOP_POS      = 44;

   typedef struct packed {
      logic [BOUND_W-1:0] lo;
      logic [BOUND_W-1:0] hi;
   } win_bounds_type;

   typedef struct packed {
      logic [31:0]        data_word;
      logic [3:0]         row_parities;
      logic [7:0]         column_parities;
      logic               stop_bit;
      logic [COUNT_W-1:0] bit_count;
      logic               word_complete;
   } result_type;

   // nominal length of a window in carrier units
   function automatic int win_units(input int full, input int win);
      int units;
      begin
         units = full;
         case (win)
            WIN_FULL:     units = full;
            WIN_ONE_HALF: units = 3 * (full / 2);
            WIN_DOUBLE:   units = 2 * full;
            WIN_TRIPLE:   units = 3 * full;
            default:      units = full;
         endcase
         return units;
      end
   endfunction

endpackage
`default_nettype wire

[sv/plwd_csr.sv]
// Configuration registers and registered pulse window bounds.
`default_nettype none
module plwd_csr #(
   parameter int FULL_PERIOD_UNITS = plwd_pkg::FULL_PERIOD_UNITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [plwd_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  wire logic [plwd_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output      logic [plwd_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output      logic                                   csr_pready,
   output      plwd_pkg::win_bounds_type [plwd_pkg::NUM_WINDOWS-1:0] bounds
);
   import plwd_pkg::*;

   logic [UNIT_TICKS_W-1:0] unit_ticks_ff;
   logic [TOLERANCE_W-1:0]  tolerance_ff;
   logic                    wr_en;
   logic                    reg_sel;
   win_bounds_type [NUM_WINDOWS-1:0] bounds_ff;
   win_bounds_type [NUM_WINDOWS-1:0] bounds_in;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= UNIT_TICKS_RESET;
         tolerance_ff  <= TOLERANCE_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            REG_UNIT_TICKS: unit_ticks_ff <= csr_pwdata[UNIT_TICKS_W-1:0];
            REG_TOLERANCE:  tolerance_ff  <= csr_pwdata[TOLERANCE_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_UNIT_TICKS: csr_prdata = CSR_DATA_W'(unit_ticks_ff);
         REG_TOLERANCE:  csr_prdata = CSR_DATA_W'(tolerance_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // one multiplier per bound, registered; lower bound clamps at zero
   for (genvar w = 0; w < NUM_WINDOWS; w++) begin : g_win
      localparam logic [UNITS_W:0] UNITS = (UNITS_W + 1)'(win_units(FULL_PERIOD_UNITS, w));
      logic [UNITS_W:0] diff;
      logic [UNITS_W:0] sum;
      always_comb begin
         diff = UNITS - (UNITS_W + 1)'(tolerance_ff);
         sum  = UNITS + (UNITS_W + 1)'(tolerance_ff);
         bounds_in[w].hi = BOUND_W'(unit_ticks_ff) * BOUND_W'(sum[UNITS_W-1:0]);
         if (diff[UNITS_W])
            bounds_in[w].lo = '0;
         else
            bounds_in[w].lo = BOUND_W'(unit_ticks_ff) * BOUND_W'(diff[UNITS_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      bounds_ff <= bounds_in;
   end

   assign bounds = bounds_ff;

endmodule
`default_nettype wire

[sv/plwd_core.sv]
// Input register, pulse classification, word buffer and result register.
`default_nettype none
`include "assert_macros.svh"
module plwd_core #(
   parameter int WORD_BITS = plwd_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire plwd_pkg::win_bounds_type [plwd_pkg::NUM_WINDOWS-1:0] bounds,
   input  wire logic                                   in_valid,
   output      logic                                   in_ready,
   input  wire logic [plwd_pkg::PULSE_W-1:0]           in_pulse_length,
   input  wire logic                                   in_word_start,
   output      logic                                   out_valid,
   input  wire logic                                   out_ready,
   output      plwd_pkg::result_type                   out_result
);
   import plwd_pkg::*;

   localparam int BUF_DEPTH = WORD_BITS + 2;
   localparam int IDX_W     = $clog2(BUF_DEPTH + 1);

   // input register
   logic                s1_valid_ff;
   logic [PULSE_W-1:0]  s1_pulse_ff;
   logic                s1_start_ff;
   logic                s1_go;
   logic                out_free;

   // word state
   logic [BUF_DEPTH-1:0] buf_ff,  buf_in;
   logic [IDX_W-1:0]     idx_ff,  idx_in;
   logic                 tog_ff,  tog_in;
   logic                 last_ff, last_in;

   // result register
   logic       rsp_valid_ff;
   result_type rsp_ff, rsp_in;

   logic [NUM_WINDOWS-1:0] fit;
   logic                   prev;
   logic [1:0]             n_push;
   logic                   b0, b1;
   logic                   clear;
   logic                   emit;
   logic [IDX_W-1:0]       idx_base;
   logic [IDX_W:0]         idx_plus1;
   logic                   st0, st1;
   logic [FIELD_SPAN-1:0]  buf_ext;
   logic [IDX_W-1:0]       cnt;

   assign out_free = ~rsp_valid_ff | out_ready;
   assign s1_go    = s1_valid_ff & out_free;
   assign in_ready = ~s1_valid_ff | out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_valid & in_ready) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid & in_ready) begin
         s1_pulse_ff <= in_pulse_length;
         s1_start_ff <= in_word_start;
      end
   end

   for (genvar w = 0; w < NUM_WINDOWS; w++) begin : g_fit
      assign fit[w] = (BOUND_W'(s1_pulse_ff) >= bounds[w].lo)
                    & (BOUND_W'(s1_pulse_ff) <= bounds[w].hi);
   end

   assign prev = (idx_ff == '0) ? 1'b0 : last_ff;

   always_comb begin
      n_push = 2'd0;
      b0     = 1'b0;
      b1     = 1'b0;
      tog_in = tog_ff;
      clear  = 1'b0;
      emit   = 1'b0;
      if (s1_start_ff) begin
         clear  = 1'b1;
         tog_in = 1'b0;
         if (fit[WIN_ONE_HALF]) begin
            n_push = 2'd1;
            b0     = 1'b1;
         end else if (fit[WIN_DOUBLE]) begin
            n_push = 2'd1;
            tog_in = 1'b1;
         end else begin
            n_push = 2'd2;
            b1     = 1'b1;
         end
      end else if (fit[WIN_FULL]) begin
         n_push = 2'd1;
         b0     = prev;
      end else if (fit[WIN_ONE_HALF]) begin
         if (tog_ff) begin
            n_push = 2'd2;
            b0     = prev;
            b1     = ~prev;
            tog_in = 1'b0;
         end else begin
            n_push = 2'd1;
            b0     = ~prev;
            tog_in = 1'b1;
         end
      end else if (fit[WIN_DOUBLE]) begin
         n_push = 2'd2;
         b1     = 1'b1;
      end else if (fit[WIN_TRIPLE]) begin
         emit   = 1'b1;
         clear  = 1'b1;
         tog_in = 1'b0;
      end
   end

   // store up to two bits; drop those past the end of the buffer
   always_comb begin
      idx_base  = clear ? '0 : idx_ff;
      idx_plus1 = {1'b0, idx_base} + (IDX_W + 1)'(1);
      st0       = (n_push != 2'd0) & (idx_base < IDX_W'(BUF_DEPTH));
      st1       = (n_push == 2'd2) & (idx_plus1 < (IDX_W + 1)'(BUF_DEPTH));
      idx_in    = idx_base + IDX_W'(st0) + IDX_W'(st1);
      last_in   = st1 ? b1 : (st0 ? b0 : last_ff);
      buf_in    = clear ? '0 : buf_ff;
      for (int k = 0; k < BUF_DEPTH; k++) begin
         if (st0 && (IDX_W'(k) == idx_base))
            buf_in[k] = b0;
         if (st1 && ((IDX_W + 1)'(k) == idx_plus1))
            buf_in[k] = b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff  <= '0;
         idx_ff  <= '0;
         tog_ff  <= 1'b0;
         last_ff <= 1'b0;
      end else if (s1_go) begin
         buf_ff  <= buf_in;
         idx_ff  <= idx_in;
         tog_ff  <= tog_in;
         last_ff <= last_in;
      end
   end

   // unpack the word; positions past the buffer read as zero
   assign buf_ext = FIELD_SPAN'(buf_ff);
   assign cnt     = (idx_ff == '0) ? '0 : idx_ff - IDX_W'(1);

   always_comb begin
      rsp_in = '0;
      for (int r = 0; r < 4; r++) begin
         for (int j = 0; j < 8; j++)
            rsp_in.data_word[31 - 8 * r - j] = buf_ext[ROW_STRIDE * r + j];
         rsp_in.row_parities[3 - r] = buf_ext[ROW_CHECK_POS + ROW_STRIDE * r];
      end
      for (int j = 0; j < 8; j++)
         rsp_in.column_parities[7 - j] = buf_ext[COL_FIRST + j];
      rsp_in.stop_bit      = buf_ext[STOP_POS];
      rsp_in.bit_count     = COUNT_W'(cnt);
      rsp_in.word_complete = (cnt == IDX_W'(WORD_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= emit;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && emit)
         rsp_ff <= rsp_in;
   end

   assign out_valid  = rsp_valid_ff;
   assign out_result = rsp_ff;

   `PLWD_ASSERT(a_idx_range, idx_ff <= IDX_W'(BUF_DEPTH), "bit index past buffer depth")
   `PLWD_ASSERT_NEXT(a_end_clears, s1_go && emit, idx_ff == '0 && !tog_ff, "word end left state")
   `PLWD_ASSERT_IMPL(a_complete_count, rsp_valid_ff && rsp_ff.word_complete,
                     rsp_ff.bit_count == COUNT_W'(WORD_BITS), "complete flag with wrong count")

endmodule
`default_nettype wire

[sv/pulse_length_word_decoder_top.sv]
// Top level of the pulse length word decoder: stream ports and register port.
`default_nettype none
// Decodes a biphase tag answer from measured pulse lengths. Each request
// transaction carries one pulse length in timer ticks and a word-start flag;
// the pulse is classified as 1, 1.5, 2 or 3 bit periods using windows of
// unit_ticks * (nominal +/- tolerance_units) and appends zero to two bits to
// a word buffer. A 3-period pulse without the word-start flag ends the
// word and produces one response transaction with the four data bytes, row
// and column parities, the stop bit and the bit count; every other pulse
// produces none, and a pulse that fits no window is ignored unless it
// starts a word. Each request is held and decoded in the input register,
// and a response is loaded from there into the response register, which
// drives rsp_tvalid; the block accepts one request per clock while the
// response side is not stalled; a stalled response holds the input
// register, which then holds req_tready low. The window bounds are
// registered multiplier outputs of the configuration registers; write
// configuration only while the block is idle. Register map: 0x0 unit_ticks
// (10 bits, reset 192), 0x4 tolerance_units (5 bits, reset 8).
module pulse_length_word_decoder_top #(
   parameter int WORD_BITS         = plwd_pkg::WORD_BITS_DEFAULT,
   parameter int FULL_PERIOD_UNITS = plwd_pkg::FULL_PERIOD_UNITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [plwd_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [15:0] pulse_length
   input  wire logic                               req_tuser,  // [0] word_start
   // response channel
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [31:0] data_word, [35:32] row_parities, [43:36] column_parities,
   // [44] stop_bit, [50:45] bit_count, [55:51] zero
   output      logic [plwd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output      logic                               rsp_tuser,  // [0] word_complete
   // register port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [plwd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [plwd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output      logic [plwd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output      logic                               csr_pready
);
   import plwd_pkg::*;

   localparam int PAD_W = RSP_TDATA_W - 32 - 4 - 8 - 1 - COUNT_W;

   win_bounds_type [NUM_WINDOWS-1:0] bounds;
   result_type                       result;

   // registers and window bounds
   plwd_csr #(
      .FULL_PERIOD_UNITS (FULL_PERIOD_UNITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .bounds      (bounds)
   );

   // classification, word buffer and response register
   plwd_core #(
      .WORD_BITS (WORD_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .bounds          (bounds),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .in_pulse_length (req_tdata[PULSE_W-1:0]),
      .in_word_start   (req_tuser),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_result      (result)
   );

   // pack the response fields, first field in the lowest bits
   assign rsp_tdata = {{PAD_W{1'b0}}, result.bit_count, result.stop_bit,
                       result.column_parities, result.row_parities, result.data_word};
   assign rsp_tuser = result.word_complete;

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench of the pulse length word decoder top level.
`timescale 1ns / 100ps
module testbench;
   import plwd_pkg::*;

   // Word geometry and nominal pulse lengths in carrier units.
   localparam int WORD_LEN    = WORD_BITS_DEFAULT;
   localparam int BUF_DEPTH   = WORD_LEN + 2;
   localparam int PERIOD      = FULL_PERIOD_UNITS_DEFAULT;

   // Traffic shaping.
   localparam int IDLE_PCT       = 30;
   localparam int NOISE_PCT      = 10;
   localparam int PHASE_ITEMS    = 180;
   localparam int NUM_PHASES     = 7;
   localparam int HOLD_CYCLES    = 250;
   localparam int HOLD_FIRST     = 300;
   localparam int HOLD_SPACING   = 600;
   localparam int QUIET_FROM     = 600;
   localparam int QUIET_TO       = 800;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum int {PULSE_FULL, PULSE_HALF3, PULSE_DOUBLE, PULSE_TRIPLE} pulse_kind_type;
   typedef enum int {AT_RANDOM, AT_LOW, AT_HIGH, BELOW_LOW, ABOVE_HIGH} probe_type;

   typedef struct packed {
      logic [UNIT_TICKS_W-1:0] unit_ticks;
      logic [TOLERANCE_W-1:0]  tolerance;
   } decode_cfg_type;

   typedef struct packed {
      logic [BUF_DEPTH-1:0] bits;
      int unsigned          held;
      logic                 toggle;
   } word_state_type;

   typedef struct packed {
      logic [PULSE_W-1:0] length;
      logic               start;
      logic               drain_first;
   } pulse_item_type;

   // ------------------------------------------------------------------
   // DUT ports, all driven to known values from time zero
   // ------------------------------------------------------------------
   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;   // [15:0] pulse_length
   logic                   req_tuser   = 1'b0; // [0] word_start
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   // [31:0] data_word, [35:32] row_parities, [43:36] column_parities,
   // [44] stop_bit, [50:45] bit_count, [55:51] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;          // [0] word_complete
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   pulse_length_word_decoder_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------------
   // Shared testbench state
   // ------------------------------------------------------------------
   decode_cfg_type  cfg          = '{unit_ticks: UNIT_TICKS_RESET, tolerance: TOLERANCE_RESET};
   word_state_type  live_word    = '0;  // follows the block, advanced on accepted pulses
   word_state_type  planned_word = '0;  // follows the queued stimulus, used for shaping
   pulse_item_type  pulse_queue[$];
   pulse_item_type  next_pulse;
   result_type   expected_words[$];
   result_type   predicted_word;
   result_type   got_word;
   result_type   want_word;
   int           items_queued   = 0;
   int           items_accepted = 0;
   int           error_count    = 0;
   int           idle_cycles    = 0;
   int           hold_left      = 0;
   int           next_hold_at   = HOLD_FIRST;
   bit           req_fire       = 1'b0;
   bit           rsp_fire       = 1'b0;
   bit           drain_next     = 1'b0;

   int phase_unit[NUM_PHASES] = '{1, 1, 1023, 1023, 37, 700, 192};
   int phase_tol[NUM_PHASES]  = '{0, 31, 31, 0, 17, 2, 8};

   // No idling on either side while this stretch of transactions goes by.
   wire quiet_stretch = (items_accepted >= QUIET_FROM) && (items_accepted < QUIET_TO);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Decoder prediction
   // ------------------------------------------------------------------
   function automatic int units_of(pulse_kind_type kind);
      case (kind)
         PULSE_HALF3:  return 3 * (PERIOD / 2);
         PULSE_DOUBLE: return 2 * PERIOD;
         PULSE_TRIPLE: return 3 * PERIOD;
         default:      return PERIOD;
      endcase
   endfunction

   // Window bounds in ticks; a negative lower bound clamps to zero.
   function automatic void window_of(input decode_cfg_type c, input pulse_kind_type kind,
                                     output longint lo, output longint hi);
      lo = longint'(c.unit_ticks) * (units_of(kind) - int'(c.tolerance));
      hi = longint'(c.unit_ticks) * (units_of(kind) + int'(c.tolerance));
      if (lo < 0) lo = 0;
   endfunction

   function automatic bit in_window(decode_cfg_type c, logic [PULSE_W-1:0] len,
                                    pulse_kind_type kind);
      longint lo, hi;
      window_of(c, kind, lo, hi);
      return longint'(len) >= lo && longint'(len) <= hi;
   endfunction

   // Append one bit; drop it once the buffer is full.
   function automatic void push_bit(inout word_state_type s, input logic b);
      if (s.held < BUF_DEPTH) begin
         s.bits[s.held] = b;
         s.held++;
      end
   endfunction

   // Advance the word state by one pulse; return 1 with the word fields on a word end.
   function automatic bit decode_pulse(inout word_state_type s, input decode_cfg_type c,
                                       input logic [PULSE_W-1:0] len, input logic start,
                                       output result_type r);
      logic        prev;
      int unsigned n;
      r = '0;
      if (start) begin
         s = '0;
         if (in_window(c, len, PULSE_HALF3)) begin
            push_bit(s, 1'b1);
         end else if (in_window(c, len, PULSE_DOUBLE)) begin
            push_bit(s, 1'b0);
            s.toggle = 1'b1;
         end else begin
            push_bit(s, 1'b0);
            push_bit(s, 1'b1);
         end
         return 1'b0;
      end
      // empty buffer reads as a previous bit of zero
      prev = (s.held == 0) ? 1'b0 : s.bits[s.held - 1];
      if (in_window(c, len, PULSE_FULL)) begin
         push_bit(s, prev);
      end else if (in_window(c, len, PULSE_HALF3)) begin
         if (s.toggle) begin
            push_bit(s, prev);
            push_bit(s, ~prev);
            s.toggle = 1'b0;
         end else begin
            push_bit(s, ~prev);
            s.toggle = 1'b1;
         end
      end else if (in_window(c, len, PULSE_DOUBLE)) begin
         push_bit(s, 1'b0);
         push_bit(s, 1'b1);
      end else if (in_window(c, len, PULSE_TRIPLE)) begin
         for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 8; j++) r.data_word[31 - 8 * k - j] = s.bits[9 * k + j];
            r.row_parities[3 - k] = s.bits[8 + 9 * k];
         end
         for (int j = 0; j < 8; j++) r.column_parities[7 - j] = s.bits[36 + j];
         r.stop_bit      = s.bits[44];
         n               = (s.held > 0) ? s.held - 1 : 0;
         r.bit_count     = n[COUNT_W-1:0];
         r.word_complete = (n == WORD_LEN);
         s = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus generation
   // ------------------------------------------------------------------
   // Pick a length in, at or just outside a window, clamped to the field range.
   function automatic logic [PULSE_W-1:0] pulse_in(decode_cfg_type c, pulse_kind_type kind,
                                                   probe_type at);
      longint lo, hi, v;
      window_of(c, kind, lo, hi);
      case (at)
         AT_LOW:     v = lo;
         AT_HIGH:    v = hi;
         BELOW_LOW:  v = lo - 1;
         ABOVE_HIGH: v = hi + 1;
         default: begin
            if (hi > 65535) hi = 65535;
            v = (lo > hi) ? 65535 : lo + longint'($urandom_range(0, 32'(hi - lo)));
         end
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[PULSE_W-1:0];
   endfunction

   function automatic logic [PULSE_W-1:0] noise_pulse(decode_cfg_type c);
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return pulse_in(c, pulse_kind_type'($urandom_range(0, 3)),
                                  probe_type'($urandom_range(1, 4)));
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic int pick_target();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return WORD_LEN + 1;     // a complete word
         4:          return $urandom_range(WORD_LEN, BUF_DEPTH + 5);
         5, 6:       return $urandom_range(1, BUF_DEPTH + 5);
         default:    return $urandom_range(20, BUF_DEPTH + 3);
      endcase
   endfunction

   task automatic add_pulse(logic [PULSE_W-1:0] len, logic start);
      result_type scratch;
      pulse_queue.push_back('{length: len, start: start, drain_first: drain_next});
      drain_next = 1'b0;
      void'(decode_pulse(planned_word, cfg, len, start, scratch));
      items_queued++;
   endtask

   // Queue one word: an opening pulse, bit pulses steered toward a bit count,
   // some noise, and usually the closing triple pulse.
   task automatic queue_word(int target);
      int budget;
      budget = target + 12;
      case ($urandom_range(0, 4))
         0, 1:    add_pulse(pulse_in(cfg, PULSE_HALF3, AT_RANDOM), 1'b1);
         2:       add_pulse(pulse_in(cfg, PULSE_DOUBLE, AT_RANDOM), 1'b1);
         3:       add_pulse(pulse_in(cfg, PULSE_TRIPLE, AT_RANDOM), 1'b1);
         default: add_pulse(noise_pulse(cfg), 1'b1);
      endcase
      while (planned_word.held < target && budget > 0) begin
         budget--;
         if ($urandom_range(0, 99) < NOISE_PCT)
            add_pulse(noise_pulse(cfg), $urandom_range(0, 39) == 0);
         else if (target - planned_word.held == 1)
            add_pulse(pulse_in(cfg, PULSE_FULL, AT_RANDOM), 1'b0);
         else
            add_pulse(pulse_in(cfg, pulse_kind_type'($urandom_range(0, 2)), AT_RANDOM), 1'b0);
      end
      if ($urandom_range(0, 9) != 0)
         add_pulse(pulse_in(cfg, PULSE_TRIPLE, AT_RANDOM), 1'b0);
   endtask

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------
   task automatic csr_write(logic regsel, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {regsel, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Wait until the block is idle, then load a new setting. Unused upper
   // data bits carry random values that the block must drop.
   task automatic apply_config(int unit, int tol);
      while (items_accepted != items_queued || expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(REG_UNIT_TICKS, ($urandom() & ~32'h3FF) | unit);
      csr_write(REG_TOLERANCE, ($urandom() & ~32'h1F) | tol);
      cfg.unit_ticks = unit[UNIT_TICKS_W-1:0];
      cfg.tolerance  = tol[TOLERANCE_W-1:0];
      // let the registered window bounds follow the new setting
      repeat (SETTLE_CYCLES) @(posedge clock);
      planned_word = live_word;
   endtask

   // ------------------------------------------------------------------
   // Request driver: accept at the rising edge, drive at the falling edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      req_fire = !reset && req_tvalid && req_tready;
      if (req_fire) begin
         items_accepted++;
         if (decode_pulse(live_word, cfg, req_tdata[PULSE_W-1:0], req_tuser, predicted_word))
            expected_words.push_back(predicted_word);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         // A drain-first item holds back until every pending word has come out.
         if (pulse_queue.size() > 0 &&
             !(pulse_queue[0].drain_first && expected_words.size() > 0) &&
             (quiet_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
            next_pulse = pulse_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_pulse.length;
            req_tuser  <= next_pulse.start;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor and receiver
   // ------------------------------------------------------------------
   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_fire = !reset && rsp_tvalid && rsp_tready;
      if (rsp_fire) begin
         got_word.data_word       = rsp_tdata[31:0];
         got_word.row_parities    = rsp_tdata[35:32];
         got_word.column_parities = rsp_tdata[43:36];
         got_word.stop_bit        = rsp_tdata[44];
         got_word.bit_count       = rsp_tdata[50:45];
         got_word.word_complete   = rsp_tuser;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual 0x%0h", $time, got_word);
            error_count++;
         end else begin
            want_word = expected_words.pop_front();
            check_field("data_word", want_word.data_word, got_word.data_word);
            check_field("row_parities", want_word.row_parities, got_word.row_parities);
            check_field("column_parities", want_word.column_parities,
                        got_word.column_parities);
            check_field("stop_bit", want_word.stop_bit, got_word.stop_bit);
            check_field("bit_count", want_word.bit_count, got_word.bit_count);
            check_field("word_complete", want_word.word_complete, got_word.word_complete);
         end
      end
   end

   // Hold off the receiver for a long stretch at a few points so that the
   // block backs up and stalls its request side; idle at random otherwise.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (items_accepted >= next_hold_at) begin
         next_hold_at += HOLD_SPACING;
         hold_left    = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run when no transaction moves for too long
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset setting.
      add_pulse(pulse_in(cfg, PULSE_HALF3, AT_RANDOM), 1'b1);   // word start on 1.5
      add_pulse(pulse_in(cfg, PULSE_FULL, AT_LOW), 1'b0);
      add_pulse(pulse_in(cfg, PULSE_HALF3, AT_HIGH), 1'b0);     // toggle run
      add_pulse(pulse_in(cfg, PULSE_HALF3, AT_LOW), 1'b0);
      add_pulse(pulse_in(cfg, PULSE_DOUBLE, AT_LOW), 1'b0);
      add_pulse(pulse_in(cfg, PULSE_DOUBLE, ABOVE_HIGH), 1'b0); // fits no window
      add_pulse('0, 1'b0);                                       // timeout, ignored
      add_pulse('1, 1'b0);
      add_pulse(pulse_in(cfg, PULSE_FULL, BELOW_LOW), 1'b0);
      add_pulse(pulse_in(cfg, PULSE_FULL, AT_HIGH), 1'b0);
      add_pulse(pulse_in(cfg, PULSE_TRIPLE, AT_HIGH), 1'b0);    // word end
      add_pulse(pulse_in(cfg, PULSE_TRIPLE, AT_LOW), 1'b0);     // word end on empty buffer
      add_pulse(pulse_in(cfg, PULSE_TRIPLE, BELOW_LOW), 1'b0);
      add_pulse(pulse_in(cfg, PULSE_DOUBLE, AT_RANDOM), 1'b1);  // start on 2, toggle pending
      add_pulse(pulse_in(cfg, PULSE_HALF3, AT_RANDOM), 1'b0);
      add_pulse(pulse_in(cfg, PULSE_HALF3, AT_RANDOM), 1'b0);
      add_pulse(pulse_in(cfg, PULSE_TRIPLE, AT_RANDOM), 1'b0);
      add_pulse(pulse_in(cfg, PULSE_TRIPLE, AT_RANDOM), 1'b1);  // start on 3 stores "01"
      add_pulse('0, 1'b1);                                       // start on timeout
      add_pulse('1, 1'b1);                                       // start on unmatched
      add_pulse(pulse_in(cfg, PULSE_FULL, AT_RANDOM), 1'b0);
      add_pulse(pulse_in(cfg, PULSE_TRIPLE, AT_RANDOM), 1'b0);

      // Random part, one setting per phase, extremes included.
      for (int p = 0; p < NUM_PHASES; p++) begin
         apply_config(phase_unit[p], phase_tol[p]);
         for (int n = 0; n < PHASE_ITEMS; n = n) begin
            // once, pause the sender until every pending word has come out
            if (p == 2 && n >= PHASE_ITEMS / 2 && n < PHASE_ITEMS / 2 + 60)
               drain_next = 1'b1;
            n = n - items_queued;
            queue_word(pick_target());
            n = n + items_queued;
         end
      end

      // Drain, then leave room for anything late.
      while (items_accepted != items_queued || expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

[pulse_length_word_decoder_top.f]
+incdir+sv
sv/plwd_pkg.sv
sv/plwd_csr.sv
sv/plwd_core.sv
sv/pulse_length_word_decoder_top.sv
tb/testbench.sv
